/* design/differential_drive_odometry_core_macros.svh */
// assertion helpers shared by the odometry core
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DDO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ddo_pkg.sv */
package ddo_pkg;

	// angle and position formats
	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int DIST_W     = 16;
	localparam int POS_W      = 40;
	localparam int HEAD_W     = 16;

	// configuration port
	localparam int TW_W      = 12;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [TW_W-1:0] TW_RESET = TW_W'(652);
	localparam logic [REG_IDX_W-1:0] REG_TRACK_WIDTH = REG_IDX_W'(0);

	// wheel sum and difference
	localparam int SUM_W = DIST_W + 1;
	localparam int MID_W = DIST_W;
	localparam int MUL_CNT_W = $clog2(MID_W);

	// heading increment divider
	localparam int GAIN   = 10430;
	localparam int GAIN_W = 14;
	localparam int ANG_UP = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int ANG_DN = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
	localparam int MAG_W  = SUM_W + GAIN_W + ANG_UP;
	localparam int DEN_W  = TW_W + ANG_DN;
	localparam int DIV_CNT_W = $clog2(MAG_W);

	// cordic
	localparam int TRIG_W       = 16;
	localparam int CORDIC_W     = 32;
	localparam int PHASE_W      = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
	localparam logic signed [CORDIC_W-1:0] CORDIC_K = 32'sd652032874;
	localparam int Q15_HALF = 1 << (TRIG_W - 2);
	localparam int Q15_MAX  = (1 << (TRIG_W - 1)) - 1;

	// position step rescale
	localparam int PROD_W = 32;
	localparam int SH_UP  = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
	localparam int SH_DN  = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
	localparam int STEP_W = PROD_W + SH_UP + 1;
	localparam logic signed [STEP_W-1:0] STEP_RND =
		(SH_DN > 0) ? STEP_W'(64'd1 << (SH_DN - 1)) : STEP_W'(0);
	localparam int ACC_W = ((STEP_W > POS_W) ? STEP_W : POS_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIG,
		ST_MUL,
		ST_DIV,
		ST_UPD
	} state_t;

	// arctangent of 2^-i as a fraction of a quarter turn times 2^30
	function automatic logic signed [CORDIC_W-1:0] atan_val(input logic [STEP_IDX_W-1:0] i);
		logic signed [CORDIC_W-1:0] a;
		case (i)
			4'd0:    a = 32'sd536870912;
			4'd1:    a = 32'sd316933406;
			4'd2:    a = 32'sd167458907;
			4'd3:    a = 32'sd85004756;
			4'd4:    a = 32'sd42667331;
			4'd5:    a = 32'sd21354465;
			4'd6:    a = 32'sd10679838;
			4'd7:    a = 32'sd5340245;
			4'd8:    a = 32'sd2670163;
			4'd9:    a = 32'sd1335087;
			4'd10:   a = 32'sd667544;
			4'd11:   a = 32'sd333772;
			4'd12:   a = 32'sd166886;
			4'd13:   a = 32'sd83443;
			4'd14:   a = 32'sd41722;
			4'd15:   a = 32'sd20861;
			default: a = '0;
		endcase
		return a;
	endfunction

	// round half up to q1.15 and clamp to the symmetric range
	function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W:0] t;
		logic signed [CORDIC_W:0] r;
		t = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(Q15_HALF);
		r = t >>> (TRIG_W - 1);
		if (r > Q15_MAX)
			r = (CORDIC_W+1)'(Q15_MAX);
		if (r < -Q15_MAX)
			r = -(CORDIC_W+1)'(Q15_MAX);
		return TRIG_W'(r);
	endfunction

endpackage

/* design/ddo_cordic.sv */
module ddo_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ddo_pkg::ANGLE_BITS-1:0] angle,
	output logic busy,
	output logic signed [ddo_pkg::TRIG_W-1:0] cos_val,
	output logic signed [ddo_pkg::TRIG_W-1:0] sin_val
);

	logic signed [ddo_pkg::CORDIC_W-1:0] x_q, y_q, z_q;
	logic signed [ddo_pkg::CORDIC_W-1:0] x_nxt, y_nxt, z_nxt;
	logic signed [ddo_pkg::CORDIC_W-1:0] xs, ys, at;
	logic [1:0] quad_q;
	logic [ddo_pkg::STEP_IDX_W-1:0] step_q;
	logic busy_q;
	logic [ddo_pkg::PHASE_W-1:0] phase;
	logic signed [ddo_pkg::TRIG_W-1:0] c_raw, s_raw;

	// angle to phase word, quadrant from the top two bits
	assign phase = {angle, {(ddo_pkg::PHASE_W-ddo_pkg::ANGLE_BITS){1'b0}}};

	// one rotation step
	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = ddo_pkg::atan_val(step_q);
		if (!z_q[ddo_pkg::CORDIC_W-1]) begin
			x_nxt = x_q - ys;
			y_nxt = y_q + xs;
			z_nxt = z_q - at;
		end else begin
			x_nxt = x_q + ys;
			y_nxt = y_q - xs;
			z_nxt = z_q + at;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == ddo_pkg::STEP_IDX_W'(ddo_pkg::CORDIC_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	// rotation datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= ddo_pkg::CORDIC_K;
			y_q    <= '0;
			z_q    <= ddo_pkg::CORDIC_W'({2'b00, phase[ddo_pkg::PHASE_W-3:0]});
			quad_q <= phase[ddo_pkg::PHASE_W-1:ddo_pkg::PHASE_W-2];
		end else if (busy_q) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			z_q <= z_nxt;
		end
	end

	// quadrant fold-back of the rounded results
	always_comb begin
		c_raw = ddo_pkg::to_q15(x_q);
		s_raw = ddo_pkg::to_q15(y_q);
		case (quad_q)
			2'd0: begin
				cos_val = c_raw;
				sin_val = s_raw;
			end
			2'd1: begin
				cos_val = -s_raw;
				sin_val = c_raw;
			end
			2'd2: begin
				cos_val = -c_raw;
				sin_val = -s_raw;
			end
			default: begin
				cos_val = s_raw;
				sin_val = -c_raw;
			end
		endcase
	end

	assign busy = busy_q;

endmodule

/* design/ddo_div.sv */
module ddo_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ddo_pkg::MAG_W-1:0] dividend,
	input  logic [ddo_pkg::DEN_W-1:0] divisor,
	output logic busy,
	output logic [ddo_pkg::MAG_W-1:0] quotient
);

	logic [ddo_pkg::MAG_W-1:0] num_q;
	logic [ddo_pkg::DEN_W-1:0] den_q;
	logic [ddo_pkg::DEN_W-1:0] rem_q;
	logic [ddo_pkg::DEN_W:0] rem_sh, rem_sub;
	logic qbit;
	logic [ddo_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q;

	// one restoring step: shift in the next dividend bit, try the subtract
	always_comb begin
		rem_sh  = {rem_q, num_q[ddo_pkg::MAG_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ddo_pkg::DIV_CNT_W'(ddo_pkg::MAG_W - 1))
				busy_q <= 1'b0;
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[ddo_pkg::MAG_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[ddo_pkg::DEN_W-1:0] : rem_sh[ddo_pkg::DEN_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;

endmodule

/* design/differential_drive_odometry_core.sv */
// Differential-drive odometry: each input transaction carries the left and
// right wheel distances of one sample period; the core updates its pose
// (x, y in signed Q.8 with saturation, heading as a 16-bit binary angle) and
// returns the new pose as one output transaction. Position uses the heading
// held before the transaction. A transaction occupies the core from its
// acceptance to the next possible acceptance: 16 iterations of the shared
// CORDIC rotator, a bit-serial multiply of the middle distance by cosine
// and sine, and the hand-off and pose update; the bit-serial heading
// divider runs alongside. A finished pose stays on the output ports while
// the next transaction is being worked on.
// track_width lives at byte address 0 of the register port; a width of zero
// freezes the heading.
`include "differential_drive_odometry_core_macros.svh"

module differential_drive_odometry_core (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ddo_pkg::ADDR_W-1:0] paddr,
	input  logic [ddo_pkg::DATA_W-1:0] pwdata,
	output logic [ddo_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [ddo_pkg::DIST_W-1:0] left_dist,
	input  logic signed [ddo_pkg::DIST_W-1:0] right_dist,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [ddo_pkg::POS_W-1:0] x_position,
	output logic signed [ddo_pkg::POS_W-1:0] y_position,
	output logic [ddo_pkg::HEAD_W-1:0] heading_angle
);

	ddo_pkg::state_t state_q, state_nxt;

	logic [ddo_pkg::TW_W-1:0] tw_q;
	logic reg_sel, reg_wr;

	logic in_fire, mul_load, mul_run, upd_fire;

	logic signed [ddo_pkg::SUM_W-1:0] dsum, ddiff;
	logic [ddo_pkg::SUM_W-1:0] abs_sum, abs_diff;
	logic [ddo_pkg::MAG_W-1:0] div_num;
	logic [ddo_pkg::DEN_W-1:0] div_den;
	logic [ddo_pkg::MAG_W-1:0] quot;
	logic div_busy, cordic_busy;
	logic signed [ddo_pkg::TRIG_W-1:0] cos_val, sin_val;

	logic mid_neg_q, d_neg_q, tw_zero_q;
	logic [ddo_pkg::MID_W-1:0] mid_mag_q, mul_sh_q;
	logic [ddo_pkg::MUL_CNT_W-1:0] mul_cnt_q;
	logic signed [ddo_pkg::TRIG_W-1:0] cos_q, sin_q;
	logic signed [ddo_pkg::PROD_W-1:0] acc_x_q, acc_y_q;

	logic signed [ddo_pkg::POS_W-1:0] x_q, y_q;
	logic [ddo_pkg::ANGLE_BITS-1:0] heading_q, delta;
	logic out_valid_q;

	logic signed [ddo_pkg::POS_W-1:0] x_nxt, y_nxt;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ddo_pkg::ADDR_W-1:2] == ddo_pkg::REG_TRACK_WIDTH);
	assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? ddo_pkg::DATA_W'(tw_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tw_q <= ddo_pkg::TW_RESET;
		else if (reg_wr)
			tw_q <= pwdata[ddo_pkg::TW_W-1:0];
	end

	// wheel sum and difference with magnitudes
	always_comb begin
		dsum     = ddo_pkg::SUM_W'(left_dist) + ddo_pkg::SUM_W'(right_dist);
		ddiff    = ddo_pkg::SUM_W'(right_dist) - ddo_pkg::SUM_W'(left_dist);
		abs_sum  = dsum[ddo_pkg::SUM_W-1] ? -dsum : dsum;
		abs_diff = ddiff[ddo_pkg::SUM_W-1] ? -ddiff : ddiff;
		div_num  = (ddo_pkg::MAG_W'(abs_diff) * ddo_pkg::MAG_W'(ddo_pkg::GAIN))
			<< ddo_pkg::ANG_UP;
		div_den  = ddo_pkg::DEN_W'(tw_q) << ddo_pkg::ANG_DN;
	end

	ddo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.angle   (heading_q),
		.busy    (cordic_busy),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	ddo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (quot)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ddo_pkg::ST_IDLE:
				if (in_valid)
					state_nxt = ddo_pkg::ST_TRIG;
			ddo_pkg::ST_TRIG:
				if (!cordic_busy)
					state_nxt = ddo_pkg::ST_MUL;
			ddo_pkg::ST_MUL:
				if (mul_cnt_q == ddo_pkg::MUL_CNT_W'(ddo_pkg::MID_W - 1))
					state_nxt = ddo_pkg::ST_DIV;
			ddo_pkg::ST_DIV:
				if (!div_busy)
					state_nxt = ddo_pkg::ST_UPD;
			ddo_pkg::ST_UPD:
				if (!out_valid_q || !out_stall)
					state_nxt = ddo_pkg::ST_IDLE;
			default:
				state_nxt = ddo_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		mul_load = 1'b0;
		mul_run  = 1'b0;
		upd_fire = 1'b0;
		case (state_q)
			ddo_pkg::ST_IDLE: in_stall = 1'b0;
			ddo_pkg::ST_TRIG: mul_load = !cordic_busy;
			ddo_pkg::ST_MUL:  mul_run = 1'b1;
			ddo_pkg::ST_DIV:  ;
			ddo_pkg::ST_UPD:  upd_fire = !out_valid_q || !out_stall;
			default:          in_stall = 1'b1;
		endcase
	end

	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ddo_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mid_neg_q <= dsum[ddo_pkg::SUM_W-1];
			mid_mag_q <= abs_sum[ddo_pkg::MID_W:1];
			d_neg_q   <= ddiff[ddo_pkg::SUM_W-1];
			tw_zero_q <= (tw_q == '0);
		end
	end

	// bit-serial multiply of the middle distance by cosine and sine, msb first
	always_ff @(posedge clk) begin
		if (mul_load) begin
			cos_q     <= cos_val;
			sin_q     <= sin_val;
			mul_sh_q  <= mid_mag_q;
			mul_cnt_q <= '0;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
		end else if (mul_run) begin
			mul_sh_q  <= mul_sh_q << 1;
			mul_cnt_q <= mul_cnt_q + 1'b1;
			acc_x_q   <= (acc_x_q <<< 1) +
				(mul_sh_q[ddo_pkg::MID_W-1] ? ddo_pkg::PROD_W'(cos_q) : '0);
			acc_y_q   <= (acc_y_q <<< 1) +
				(mul_sh_q[ddo_pkg::MID_W-1] ? ddo_pkg::PROD_W'(sin_q) : '0);
		end
	end

	// rescale a product to the position format and add with saturation
	function automatic logic signed [ddo_pkg::POS_W-1:0] pos_update(
		input logic signed [ddo_pkg::POS_W-1:0] pos,
		input logic signed [ddo_pkg::PROD_W-1:0] acc,
		input logic neg
	);
		logic signed [ddo_pkg::PROD_W-1:0] p;
		logic signed [ddo_pkg::STEP_W-1:0] pe, st;
		logic signed [ddo_pkg::ACC_W-1:0] s;
		logic in_range;
		p  = neg ? -acc : acc;
		pe = ddo_pkg::STEP_W'(p);
		st = (ddo_pkg::FRAC_BITS >= 15) ? (pe <<< ddo_pkg::SH_UP)
			: ((pe + ddo_pkg::STEP_RND) >>> ddo_pkg::SH_DN);
		s  = ddo_pkg::ACC_W'(pos) + ddo_pkg::ACC_W'(st);
		in_range = (s[ddo_pkg::ACC_W-1:ddo_pkg::POS_W-1] == '0) ||
			(s[ddo_pkg::ACC_W-1:ddo_pkg::POS_W-1] == '1);
		if (in_range)
			return s[ddo_pkg::POS_W-1:0];
		else if (s[ddo_pkg::ACC_W-1])
			return {1'b1, {(ddo_pkg::POS_W-1){1'b0}}};
		else
			return {1'b0, {(ddo_pkg::POS_W-1){1'b1}}};
	endfunction

	always_comb begin
		x_nxt = pos_update(x_q, acc_x_q, mid_neg_q);
		y_nxt = pos_update(y_q, acc_y_q, mid_neg_q);
		delta = quot[ddo_pkg::ANGLE_BITS-1:0];
	end

	// pose update and output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			heading_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new pose sets valid, an accepted one clears it
			out_valid_q <= upd_fire || (out_valid_q && out_stall);
			if (upd_fire) begin
				x_q <= x_nxt;
				y_q <= y_nxt;
				if (!tw_zero_q)
					heading_q <= d_neg_q ? heading_q - delta : heading_q + delta;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign x_position    = x_q;
	assign y_position    = y_q;
	assign heading_angle = ddo_pkg::HEAD_W'(heading_q);

	`DDO_ASSERT_NEXT(a_accept_starts_units, clk, arst_n, in_fire, cordic_busy && div_busy, "units not started on accept")
	`DDO_ASSERT_SAME(a_mul_after_cordic, clk, arst_n, state_q == ddo_pkg::ST_MUL, !cordic_busy, "multiply while cordic busy")
	`DDO_ASSERT_SAME(a_update_after_div, clk, arst_n, state_q == ddo_pkg::ST_UPD, !div_busy, "pose update while divider busy")
	`DDO_ASSERT_NEXT(a_update_gives_result, clk, arst_n, upd_fire, out_valid_q, "pose update without result")
	`DDO_ASSERT_NEXT(a_zero_width_holds_heading, clk, arst_n, upd_fire && tw_zero_q, $stable(heading_q), "heading moved at zero track width")

endmodule
